FILE: src/pff_pkg.sv
// Package for the Pareto front filter: sizes, point word layout, states.
// No dependencies.
package pff_pkg;
	localparam int MAX_POINTS = 64;
	localparam int ADDR_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	typedef struct packed {
		logic signed [31:0] cost;
		logic signed [31:0] second;
		logic [15:0] id;
	} point_t;

	localparam int POINT_W = $bits(point_t);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_EMIT_A,
		ST_EMIT_B,
		ST_EMIT_C
	} state_t;
endpackage

FILE: src/pff_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pff_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: src/pareto_front_filter_top.sv
// Pareto front filter top: point store, selection scan, front emission.
// Depends on pff_pkg and pff_ram.
//
//  channel | direction | handshake            | payload
//  input   | in        | in_valid / in_stall  | cost_value second_value point_id last_point
//  output  | out       | out_valid / out_stall| front_cost front_second front_id front_size
//          |           |                      | end_of_front overflow_flag
//
// Loading accepts a word whenever in_valid is high. After the last word, each
// front point is found by one pass over the N stored points through the point
// RAM read port, until a pass finds none; each front word is then emitted via
// EMIT_A, EMIT_B and EMIT_C, held by output stalls. No clearing pass after reset.
// Input is stalled from the last word until the final front word is registered.
module pareto_front_filter_top
	import pff_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] cost_value,
	input  logic signed [31:0] second_value,
	input  logic [15:0]        point_id,
	input  logic               last_point,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] front_cost,
	output logic signed [31:0] front_second,
	output logic [15:0]        front_id,
	output logic [6:0]         front_size,
	output logic               end_of_front,
	output logic               overflow_flag
);
	state_t state_q, state_d;

	logic [CNT_W-1:0]  cnt_q, fcnt_q, rd_ptr_q, e_q;
	logic              drop_q;
	logic              valid_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic              found_q, have_best_q;
	point_t            cand_q;
	logic [ADDR_W-1:0] cand_idx_q;
	logic signed [31:0] best_q;
	logic              out_valid_q;
	point_t            out_pt_q;
	logic              out_end_q, out_ovf_q;
	logic [6:0]        out_size_q;

	logic              in_acc, store_ok, pass_end, out_load;
	logic              p_we;
	logic [ADDR_W-1:0] p_raddr;
	point_t            p_wdata, p_rdata;
	logic [POINT_W-1:0] p_rbits;
	logic [ADDR_W-1:0] f_rdata;
	logic              f_we;
	logic              eligible, better;

	assign in_acc   = in_valid && !in_stall;
	assign store_ok = cnt_q < CNT_W'(MAX_POINTS);
	assign p_we     = in_acc && store_ok;
	assign p_wdata  = '{cost: cost_value, second: second_value, id: point_id};
	assign p_rdata  = point_t'(p_rbits);
	assign pass_end = (state_q == ST_SCAN) && (rd_ptr_q == cnt_q) && !valid_s1;
	assign f_we     = pass_end && found_q;
	assign out_load = (state_q == ST_EMIT_C) && (!out_valid_q || !out_stall);

	always_comb begin
		case (state_q)
			ST_EMIT_B, ST_EMIT_C: p_raddr = f_rdata;
			default:              p_raddr = rd_ptr_q[ADDR_W-1:0];
		endcase
	end

	pff_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_point_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rbits)
	);

	pff_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_POINTS)) u_front_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (fcnt_q[ADDR_W-1:0]),
		.wdata (cand_idx_q),
		.raddr (e_q[ADDR_W-1:0]),
		.rdata (f_rdata)
	);

	assign eligible = !have_best_q || (p_rdata.second > best_q);
	assign better   = !found_q || (p_rdata.cost < cand_q.cost) ||
		((p_rdata.cost == cand_q.cost) && (p_rdata.second > cand_q.second));

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			ST_LOAD: begin
				in_stall = 1'b0;
				if (in_valid && last_point) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (pass_end && !found_q) begin
					state_d = ST_EMIT_A;
				end
			end
			ST_EMIT_A: state_d = ST_EMIT_B;
			ST_EMIT_B: state_d = ST_EMIT_C;
			ST_EMIT_C: begin
				if (out_load) begin
					state_d = (e_q + 1'b1 == fcnt_q) ? ST_LOAD : ST_EMIT_A;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			fcnt_q      <= '0;
			rd_ptr_q    <= '0;
			e_q         <= '0;
			valid_s1    <= 1'b0;
			found_q     <= 1'b0;
			have_best_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				if (store_ok) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					drop_q <= 1'b1;
				end
			end
			valid_s1 <= (state_q == ST_SCAN) && (rd_ptr_q != cnt_q);
			if (state_q == ST_SCAN) begin
				if (rd_ptr_q != cnt_q) begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end else if (pass_end) begin
					rd_ptr_q <= '0;
				end
				if (valid_s1 && eligible && better) begin
					found_q <= 1'b1;
				end else if (pass_end) begin
					found_q <= 1'b0;
				end
				if (pass_end && found_q) begin
					fcnt_q      <= fcnt_q + 1'b1;
					have_best_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (e_q + 1'b1 == fcnt_q) begin
					cnt_q       <= '0;
					drop_q      <= 1'b0;
					fcnt_q      <= '0;
					e_q         <= '0;
					have_best_q <= 1'b0;
				end else begin
					e_q <= e_q + 1'b1;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_ptr_q[ADDR_W-1:0];
		if (state_q == ST_SCAN && valid_s1 && eligible && better) begin
			cand_q     <= p_rdata;
			cand_idx_q <= idx_s1;
		end
		if (f_we) begin
			best_q <= cand_q.second;
		end
		if (out_load) begin
			out_pt_q   <= p_rdata;
			out_end_q  <= (e_q + 1'b1 == fcnt_q);
			out_ovf_q  <= drop_q;
			out_size_q <= 7'(fcnt_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign front_cost    = out_pt_q.cost;
	assign front_second  = out_pt_q.second;
	assign front_id      = out_pt_q.id;
	assign front_size    = out_size_q;
	assign end_of_front  = out_end_q;
	assign overflow_flag = out_ovf_q;

	a_front_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= cnt_q) else $error("front count exceeds point count");
	a_scan_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		rd_ptr_q <= cnt_q) else $error("scan pointer beyond point count");
	a_emit_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_A || state_q == ST_EMIT_C) |-> e_q < fcnt_q)
		else $error("emit index beyond front");
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> cnt_q != '0) else $error("scan of empty set");
endmodule

FILE: tb/tb_pareto_front_filter_top.sv
// Testbench for pareto_front_filter_top: random and directed point sets, a
// sorting front predictor and a word checker. Depends on pff_pkg and the RTL.
`timescale 1ns / 100ps

module tb_pareto_front_filter_top
	import pff_pkg::*;
();

	typedef struct {
		logic signed [31:0] cost;
		logic signed [31:0] second;
		logic [15:0]        id;
		logic               last;
	} point_word_t;

	typedef struct {
		logic signed [31:0] cost;
		logic signed [31:0] second;
		logic [15:0]        id;
		logic [6:0]         size;
		logic               eof;
		logic               ovf;
	} front_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] cost_value = '0;
	logic signed [31:0] second_value = '0;
	logic [15:0]        point_id = '0;
	logic               last_point = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] front_cost;
	logic signed [31:0] front_second;
	logic [15:0]        front_id;
	logic [6:0]         front_size;
	logic               end_of_front;
	logic               overflow_flag;

	pareto_front_filter_top i_dut (.*);

	always #5 clk = ~clk;

	point_word_t pending_points[$];
	front_word_t expected_front[$];
	point_t      sorted_set[$];
	logic        set_dropped = 1'b0;
	int          errors = 0;
	int          fronts_seen = 0;
	int          words_checked = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_cycles = 0;
	int          quiet_cycles = 0;

	function automatic bit point_first(point_t a, point_t b);
		if (a.cost != b.cost)
			return a.cost < b.cost;
		return a.second > b.second;
	endfunction

	task automatic predict_front(point_word_t w);
		point_t      p;
		int          pos;
		int          n;
		int          m;
		front_word_t fw;
		logic signed [31:0] best;
		p.cost = w.cost;
		p.second = w.second;
		p.id = w.id;
		if (sorted_set.size() < MAX_POINTS) begin
			pos = sorted_set.size();
			while (pos > 0 && point_first(p, sorted_set[pos - 1]))
				pos--;
			sorted_set.insert(pos, p);
		end else begin
			set_dropped = 1'b1;
		end
		if (!w.last)
			return;
		n = 0;
		best = '0;
		foreach (sorted_set[k]) begin
			if (n == 0 || sorted_set[k].second > best) begin
				best = sorted_set[k].second;
				n++;
			end
		end
		best = '0;
		m = 0;
		for (int k = 0; k < sorted_set.size(); k++) begin
			if (m == 0 || sorted_set[k].second > best) begin
				best = sorted_set[k].second;
				m++;
				fw.cost = sorted_set[k].cost;
				fw.second = sorted_set[k].second;
				fw.id = sorted_set[k].id;
				fw.size = n[6:0];
				fw.eof = (m == n);
				fw.ovf = set_dropped;
				expected_front.insert(expected_front.size(), fw);
			end
		end
		sorted_set.delete();
		set_dropped = 1'b0;
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		point_word_t w;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				w.cost = cost_value;
				w.second = second_value;
				w.id = point_id;
				w.last = last_point;
				predict_front(w);
			end
			if (!in_valid || !in_stall) begin
				if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					w = pending_points.pop_front();
					in_valid <= 1'b1;
					cost_value <= w.cost;
					second_value <= w.second;
					point_id <= w.id;
					last_point <= w.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		front_word_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_front.size() == 0) begin
					report_mismatch("unexpected word", front_id, 0);
				end else begin
					e = expected_front.pop_front();
					words_checked++;
					if (front_cost !== e.cost) report_mismatch("front_cost", front_cost, e.cost);
					if (front_second !== e.second)
						report_mismatch("front_second", front_second, e.second);
					if (front_id !== e.id) report_mismatch("front_id", front_id, e.id);
					if (front_size !== e.size) report_mismatch("front_size", front_size, e.size);
					if (end_of_front !== e.eof)
						report_mismatch("end_of_front", end_of_front, e.eof);
					if (overflow_flag !== e.ovf)
						report_mismatch("overflow_flag", overflow_flag, e.ovf);
					if (e.eof) fronts_seen++;
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 40000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic signed [31:0] rand_value(int spread);
		case ($urandom_range(9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $urandom();
			default: return $signed($urandom_range(2 * spread)) - spread;
		endcase
	endfunction

	task automatic queue_set(int n, int spread);
		point_word_t w;
		for (int k = 0; k < n; k++) begin
			w.cost = rand_value(spread);
			w.second = rand_value(spread);
			w.id = 16'($urandom());
			w.last = (k == n - 1);
			pending_points.insert(pending_points.size(), w);
		end
	endtask

	task automatic queue_point(int c, int s, int id, bit last);
		point_word_t w;
		w.cost = c;
		w.second = s;
		w.id = id[15:0];
		w.last = last;
		pending_points.insert(pending_points.size(), w);
	endtask

	task automatic drain;
		while (pending_points.size() > 0 || in_valid || expected_front.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int queued;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 21;
		recv_idle_pct = 83;
		// directed: single point, extremes, ties, duplicates, dominated chain
		queue_point(32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF, 1'b1);
		queue_point(5, 7, 1, 1'b0);
		queue_point(5, 7, 2, 1'b0);
		queue_point(5, 9, 3, 1'b0);
		queue_point(32'sh8000_0000, 32'sh8000_0000, 0, 1'b0);
		queue_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 4, 1'b1);
		queue_point(1, 10, 5, 1'b0);
		queue_point(2, 20, 6, 1'b0);
		queue_point(3, 15, 7, 1'b0);
		queue_point(-3, -40, 8, 1'b1);
		drain();
		// overflow: 66 points, the last two dropped
		queue_set(MAX_POINTS + 2, 1000);
		queued = 76;
		while (queued < 190) begin
			queue_set($urandom_range(1, 12), $urandom_range(1, 3) * 100);
			queued = pending_points.size() + 76;
		end
		drain();
		// long receiver hold while the sender keeps offering
		send_idle_pct = 83;
		recv_idle_pct = 21;
		hold_cycles = 2000;
		queue_set(20, 50);
		queue_set(8, 50);
		queued = 190;
		while (queued < 300) begin
			queue_set($urandom_range(1, 12), 500);
			queued += 6;
		end
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_set(MAX_POINTS, 100000);
		for (int k = 0; k < 8; k++)
			queue_set($urandom_range(1, 10), 20);
		drain();
		repeat (50) @(posedge clk);
		$display("Covered %0d front words in %0d fronts, incl. overflow, ties and stalls.",
			words_checked, fronts_seen);
		if (errors == 0 && expected_front.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

FILE: filelist.f
src/pff_pkg.sv
src/pff_ram.sv
src/pareto_front_filter_top.sv
tb/tb_pareto_front_filter_top.sv
